FILE: sv/baro_pkg.sv
// Shared constants and types for the barometer compensation pipeline.
package baro_pkg;

  // Calibration register map, one register per 32-bit word.
  localparam int NumRegs = 6;
  localparam logic [2:0] RegSens     = 3'd0;
  localparam logic [2:0] RegOff      = 3'd1;
  localparam logic [2:0] RegTcs      = 3'd2;
  localparam logic [2:0] RegTco      = 3'd3;
  localparam logic [2:0] RegTref     = 3'd4;
  localparam logic [2:0] RegTempsens = 3'd5;

  // Number of register stages from input word to output word.
  localparam int NumStg = 7;

  // Temperature thresholds in hundredths of a degree.
  localparam int TempRef   = 2000;
  localparam int TempLow   = -1500;
  // Threshold of the cold correction, relative to the reference temperature.
  localparam int DeltaLow  = TempLow - TempRef;

  // Offset and sensitivity after the second-order correction fit in 40 bits.
  typedef logic signed [39:0] wide_t;

  // Calibration word.
  typedef logic [15:0] cal_t;

endpackage

FILE: sv/barometer_compensation.sv
// Barometer compensation: seven-stage pipeline from raw conversions to temperature and pressure.
//
// One raw pressure / raw temperature word goes in and one compensated
// temperature (0.01 C) and pressure (Pa, low 32 bits) word comes out. The
// datapath is a seven-stage pipeline: it takes one word per clock while the
// output side does not stall. Stages are: temperature difference; the four
// products against dT; first-order offset and sensitivity with the squared
// temperature terms; second-order correction; the pressure product as two
// partial products; their sum; the final offset subtract and shift into the
// output register. Each stage holds its word until the next stage frees up,
// so bubbles are squeezed out under backpressure. Calibration registers are
// read directly by the stages and must only be written while the pipeline
// is empty.
module barometer_compensation (
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [23:0] raw_pressure, [47:24] raw_temperature
  input  logic [47:0] s_axis_tdata,
  // Output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [18:0] temperature_centi, [50:19] pressure_pa, [55:51] zero
  output logic [55:0] m_axis_tdata
);

  localparam int NStg = baro_pkg::NumStg;

  // ---------------------------------------------------------------------
  // Calibration registers
  // ---------------------------------------------------------------------
  baro_pkg::cal_t cal_q [baro_pkg::NumRegs];
  logic           cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  // A write to an address past the last register is dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < baro_pkg::NumRegs; i++) begin
        cal_q[i] <= '0;
      end
    end else if (cfg_wr) begin
      for (int i = 0; i < baro_pkg::NumRegs; i++) begin
        if (paddr[4:2] == 3'(i)) begin
          cal_q[i] <= pwdata[15:0];
        end
      end
    end
  end

  // Read data follows the address.
  always_comb begin
    case (paddr[4:2])
      baro_pkg::RegSens:     prdata = {16'd0, cal_q[baro_pkg::RegSens]};
      baro_pkg::RegOff:      prdata = {16'd0, cal_q[baro_pkg::RegOff]};
      baro_pkg::RegTcs:      prdata = {16'd0, cal_q[baro_pkg::RegTcs]};
      baro_pkg::RegTco:      prdata = {16'd0, cal_q[baro_pkg::RegTco]};
      baro_pkg::RegTref:     prdata = {16'd0, cal_q[baro_pkg::RegTref]};
      baro_pkg::RegTempsens: prdata = {16'd0, cal_q[baro_pkg::RegTempsens]};
      default:               prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Pipeline flow control
  // ---------------------------------------------------------------------
  logic [NStg-1:0] vld_q;
  logic [NStg:0]   rdy;

  // A stage can load when it is empty or its word moves on this cycle.
  always_comb begin
    rdy[NStg] = m_axis_tready;
    for (int k = NStg - 1; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) begin
        vld_q[0] <= s_axis_tvalid;
      end
      for (int k = 1; k < NStg; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  assign s_axis_tready = rdy[0];
  assign m_axis_tvalid = vld_q[NStg-1];

  // ---------------------------------------------------------------------
  // Datapath
  // ---------------------------------------------------------------------
  // Stage 0: temperature difference dT.
  logic signed [24:0] dt_d;
  logic [23:0]        s0_d1_q;
  logic signed [24:0] s0_dt_q;

  assign dt_d = $signed({1'b0, s_axis_tdata[47:24]})
              - $signed({1'b0, cal_q[baro_pkg::RegTref], 8'd0});

  // Stage 1: products of dT with the temperature, offset and sensitivity
  // coefficients, and dT squared.
  logic signed [41:0] mt_d, mo_d, ms_d;
  logic signed [49:0] dsq_d;
  logic signed [41:0] s1_mt_q, s1_mo_q, s1_ms_q;
  logic [16:0]        s1_t2_q;
  logic [23:0]        s1_d1_q;

  assign mt_d  = s0_dt_q * $signed({1'b0, cal_q[baro_pkg::RegTempsens]});
  assign mo_d  = s0_dt_q * $signed({1'b0, cal_q[baro_pkg::RegTco]});
  assign ms_d  = s0_dt_q * $signed({1'b0, cal_q[baro_pkg::RegTcs]});
  assign dsq_d = s0_dt_q * s0_dt_q;

  // Stage 2: first-order offset and sensitivity; squared temperature terms.
  logic signed [18:0] d_w, e_w;
  logic signed [37:0] fsq_w, gsq_w;
  baro_pkg::wide_t    off1_d, sens1_d;
  logic signed [18:0] s2_d_q;
  logic [35:0]        s2_f_q, s2_g_q;
  baro_pkg::wide_t    s2_off_q, s2_sens_q;
  logic [16:0]        s2_t2_q;
  logic [23:0]        s2_d1_q;

  assign d_w     = s1_mt_q[41:23];
  assign e_w     = d_w - 19'(baro_pkg::DeltaLow);
  assign fsq_w   = d_w * d_w;
  assign gsq_w   = e_w * e_w;
  assign off1_d  = $signed({8'd0, cal_q[baro_pkg::RegOff], 16'd0})
                 + $signed({{5{s1_mo_q[41]}}, s1_mo_q[41:7]});
  assign sens1_d = $signed({9'd0, cal_q[baro_pkg::RegSens], 15'd0})
                 + $signed({{6{s1_ms_q[41]}}, s1_ms_q[41:8]});

  // Stage 3: second-order correction below the reference temperature, with
  // the extra cold term below the low threshold.
  logic               cold, very_cold;
  logic [38:0]        f5_w, g7_w;
  logic [39:0]        g11_w, off2_w, sens2_w;
  baro_pkg::wide_t    off3_d, sens3_d;
  logic signed [19:0] temp3_d;
  baro_pkg::wide_t    s3_off_q, s3_sens_q;
  logic [18:0]        s3_temp_q;
  logic [23:0]        s3_d1_q;

  assign cold      = s2_d_q[18];
  assign very_cold = s2_d_q < 19'(baro_pkg::DeltaLow);
  assign f5_w      = {1'b0, s2_f_q, 2'b00} + 39'(s2_f_q);
  assign g7_w      = {s2_g_q, 3'b000} - 39'(s2_g_q);
  assign g11_w     = {1'b0, s2_g_q, 3'b000} + 40'({s2_g_q, 1'b0}) + 40'(s2_g_q);
  assign off2_w    = 40'(f5_w[38:1]) + (very_cold ? 40'(g7_w) : 40'd0);
  assign sens2_w   = 40'(f5_w[38:2]) + (very_cold ? 40'(g11_w[39:1]) : 40'd0);
  assign off3_d    = cold ? s2_off_q - $signed(off2_w) : s2_off_q;
  assign sens3_d   = cold ? s2_sens_q - $signed(sens2_w) : s2_sens_q;
  assign temp3_d   = 20'(baro_pkg::TempRef) + 20'(s2_d_q)
                   - (cold ? $signed({3'd0, s2_t2_q}) : 20'sd0);

  // Stage 4: pressure product as two partial products over the split
  // sensitivity.
  logic [43:0]        plo_d;
  logic signed [44:0] phi_d;
  logic [43:0]        s4_plo_q;
  logic signed [44:0] s4_phi_q;
  baro_pkg::wide_t    s4_off_q;
  logic [18:0]        s4_temp_q;

  assign plo_d = s3_d1_q * s3_sens_q[19:0];
  assign phi_d = $signed({1'b0, s3_d1_q}) * $signed(s3_sens_q[39:20]);

  // Stage 5: full product, scaled down by 2^21.
  logic signed [64:0] prod_w;
  logic signed [43:0] s5_q_q;
  baro_pkg::wide_t    s5_off_q;
  logic [18:0]        s5_temp_q;

  assign prod_w = $signed({s4_phi_q, 20'd0}) + $signed({21'd0, s4_plo_q});

  // Stage 6: subtract the offset and scale down by 2^15 into the output word.
  logic signed [44:0] x_w;
  logic [31:0]        pres_d;
  logic [31:0]        s6_pres_q;
  logic [18:0]        s6_temp_q;

  assign x_w    = $signed({s5_q_q[43], s5_q_q}) - $signed({{5{s5_off_q[39]}}, s5_off_q});
  assign pres_d = {{2{x_w[44]}}, x_w[44:15]};

  // Stage registers load whenever their stage is free to take a new word.
  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      s0_d1_q <= s_axis_tdata[23:0];
      s0_dt_q <= dt_d;
    end
    if (rdy[1]) begin
      s1_mt_q <= mt_d;
      s1_mo_q <= mo_d;
      s1_ms_q <= ms_d;
      s1_t2_q <= dsq_d[47:31];
      s1_d1_q <= s0_d1_q;
    end
    if (rdy[2]) begin
      s2_d_q    <= d_w;
      s2_f_q    <= fsq_w[35:0];
      s2_g_q    <= gsq_w[35:0];
      s2_off_q  <= off1_d;
      s2_sens_q <= sens1_d;
      s2_t2_q   <= s1_t2_q;
      s2_d1_q   <= s1_d1_q;
    end
    if (rdy[3]) begin
      s3_off_q  <= off3_d;
      s3_sens_q <= sens3_d;
      s3_temp_q <= temp3_d[18:0];
      s3_d1_q   <= s2_d1_q;
    end
    if (rdy[4]) begin
      s4_plo_q  <= plo_d;
      s4_phi_q  <= phi_d;
      s4_off_q  <= s3_off_q;
      s4_temp_q <= s3_temp_q;
    end
    if (rdy[5]) begin
      s5_q_q    <= prod_w[64:21];
      s5_off_q  <= s4_off_q;
      s5_temp_q <= s4_temp_q;
    end
    if (rdy[6]) begin
      s6_pres_q <= pres_d;
      s6_temp_q <= s5_temp_q;
    end
  end

  assign m_axis_tdata = {5'd0, s6_pres_q, s6_temp_q};

endmodule

FILE: sv/baro_checker.sv
// Port-level checks for the barometer compensation block, bound to its top level.
module baro_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [4:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata,
  input logic        pready,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [47:0] s_axis_tdata,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata
);

  // A register reads back what was last written to it.
  a_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(psel && penable && pwrite && pready) && ($past(paddr[4:2]) < 3'd6)
     && (paddr[4:2] == $past(paddr[4:2])))
    |-> (prdata == {16'd0, $past(pwdata[15:0])}))
    else $error("calibration register does not read back the written word");

  // With the output side ready, the whole pipeline moves and input is taken.
  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled although the output side is ready");

  // A stalled result word stays offered.
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    else $error("result word withdrawn while stalled");

  // A stalled result word keeps its data.
  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("result word changed while stalled");

endmodule

bind barometer_compensation baro_checker u_baro_checker (.*);
